>>> hw/rtl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define HLV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be true outside reset
`define HLV_ASSERT_NEVER(label, cond, msg) \
  `HLV_ASSERT(label, !(cond), msg)

`endif

>>> hw/rtl/hlv_pkg.sv
package hlv_pkg;

  // accumulator geometry
  localparam int unsigned ANGLES    = 256;
  localparam int unsigned ANGLE_W   = 8;
  localparam int unsigned RHO_BINS  = 2048;
  localparam int unsigned RHO_W     = 11;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned ACC_AW    = RHO_W + ANGLE_W;
  localparam int unsigned ACC_DEPTH = 1 << ACC_AW;

  // field widths
  localparam int unsigned DIM_W    = 10;
  localparam int unsigned TRIG_W   = 16;
  localparam int unsigned OFFS_W   = 10;
  localparam int unsigned ACNT_W   = 9;
  localparam int unsigned DROP_W   = 9;
  localparam int unsigned PIXEL_W  = 16;
  localparam int unsigned FRAC_W   = 14;
  localparam int unsigned PROD_W   = TRIG_W + DIM_W + 1;
  localparam int unsigned SUM_W    = PROD_W + 1;
  localparam int unsigned RRND_W   = SUM_W - FRAC_W;
  localparam int unsigned RHO_SW   = RRND_W + 1;

  // round half up of a q1.14 projection
  localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(1) << (FRAC_W - 1);

  // configuration register indexes
  localparam logic CFG_RHO_OFFSET  = 1'b0;
  localparam logic CFG_ANGLE_COUNT = 1'b1;

  localparam logic [OFFS_W-1:0] RHO_OFFSET_RST  = OFFS_W'(1023);
  localparam logic [ACNT_W-1:0] ANGLE_COUNT_RST = ACNT_W'(180);

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_VOTE  = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_e;

  // angle table write
  typedef struct packed {
    logic                     we;
    logic [ANGLE_W-1:0]       idx;
    logic signed [TRIG_W-1:0] cosine;
    logic signed [TRIG_W-1:0] sine;
  } angle_load_t;

  // one angle step issued into the projection pipe
  typedef struct packed {
    logic               valid;
    logic               last;
    logic [ANGLE_W-1:0] angle;
  } angle_issue_t;

  // projected vote for one angle
  typedef struct packed {
    logic              valid;
    logic              last;
    logic              hit;
    logic [ACC_AW-1:0] addr;
  } proj_t;

endpackage

>>> hw/rtl/hlv_proj.sv
module hlv_proj
  import hlv_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  angle_load_t        load_i,
  input  angle_issue_t       issue_i,
  input  logic [DIM_W-1:0]   row_i,
  input  logic [DIM_W-1:0]   col_i,
  input  logic [OFFS_W-1:0]  rho_offset_i,
  output proj_t              proj_o
);

  // cosine in the upper half, sine in the lower half
  logic [2*TRIG_W-1:0] tbl_mem [ANGLES];
  logic [2*TRIG_W-1:0] tbl_rd_q;

  logic               s1_valid_q, s1_last_q;
  logic [ANGLE_W-1:0] s1_angle_q;
  logic               s2_valid_q, s2_last_q;
  logic [ANGLE_W-1:0] s2_angle_q;
  logic signed [PROD_W-1:0] prod_cos_q, prod_sin_q;
  proj_t proj_q, proj_d;

  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  biased;
  logic signed [RRND_W-1:0] rho_rnd;
  logic signed [RHO_SW-1:0] rho;
  logic [RHO_SW-1:0]        top;

  // angle table, synchronous read
  always_ff @(posedge clk_i) begin
    if (load_i.we) begin
      tbl_mem[load_i.idx] <= {load_i.cosine, load_i.sine};
    end
    if (issue_i.valid) begin
      tbl_rd_q <= tbl_mem[issue_i.angle];
    end
  end

  // products of table entry and pixel coordinates
  always_ff @(posedge clk_i) begin
    prod_cos_q <= PROD_W'($signed(tbl_rd_q[2*TRIG_W-1:TRIG_W]) * $signed({1'b0, col_i}));
    prod_sin_q <= PROD_W'($signed(tbl_rd_q[TRIG_W-1:0]) * $signed({1'b0, row_i}));
  end

  // round, add offset, range check
  always_comb begin
    sum     = SUM_W'(prod_cos_q) + SUM_W'(prod_sin_q);
    biased  = sum + $signed(ROUND_BIAS);
    rho_rnd = biased[SUM_W-1:FRAC_W];
    rho     = RHO_SW'(rho_rnd) + $signed({{(RHO_SW-OFFS_W){1'b0}}, rho_offset_i});
    top     = {{(RHO_SW-OFFS_W-1){1'b0}}, rho_offset_i, 1'b0};

    proj_d.valid = s2_valid_q;
    proj_d.last  = s2_last_q;
    proj_d.hit   = !rho[RHO_SW-1] && (rho <= $signed(top))
                   && (rho < $signed(RHO_SW'(RHO_BINS)));
    proj_d.addr  = {rho[RHO_W-1:0], s2_angle_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      proj_q     <= '0;
    end else begin
      s1_valid_q <= issue_i.valid;
      s2_valid_q <= s1_valid_q;
      proj_q     <= proj_d;
    end
  end

  // sideband that travels with each angle
  always_ff @(posedge clk_i) begin
    s1_last_q  <= issue_i.last;
    s1_angle_q <= issue_i.angle;
    s2_last_q  <= s1_last_q;
    s2_angle_q <= s1_angle_q;
  end

  assign proj_o = proj_q;

endmodule

>>> hw/rtl/hough_line_vote_unit.sv
// a load writes the angle table on the accepted beat, a read fetches one
// accumulator entry, a clear zeroes all 2^19 entries, and a vote walks angles
// 0 to n-1, n = angle_count clipped to 256; none for a zero pixel or n = 0
// throughput: one item at a time; a vote walks one angle per cycle through
// the accumulator read-modify-write port; reset: a clearing pass zeroes all
// 2^19 entries, input stalled meanwhile; config registers load their defaults
module hough_line_vote_unit
  import hlv_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // config port
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [OFFS_W-1:0]        cfg_data_i,
  // input channel
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               func_i,
  input  logic [DIM_W-1:0]         row_i,
  input  logic [DIM_W-1:0]         col_i,
  input  logic [PIXEL_W-1:0]       pixel_value_i,
  input  logic [ANGLE_W-1:0]       angle_index_i,
  input  logic signed [TRIG_W-1:0] cosine_value_i,
  input  logic signed [TRIG_W-1:0] sine_value_i,
  input  logic [RHO_W-1:0]         rho_index_i,
  // output channel
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [COUNT_W-1:0]       vote_total_o,
  output logic [DROP_W-1:0]        dropped_votes_o
);

`include "assert_macros.svh"

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_VOTE,
    ST_DRAIN,
    ST_READ,
    ST_DONE
  } state_e;

  state_e state_q;

  logic [OFFS_W-1:0]  rho_offset_q;
  logic [ACNT_W-1:0]  angle_count_q;
  logic [DIM_W-1:0]   row_q, col_q;
  logic [ACNT_W-1:0]  n_q;
  logic [ACNT_W-1:0]  issue_cnt_q;
  logic [ACC_AW-1:0]  clr_cnt_q;
  logic               clr_item_q;
  logic [DROP_W-1:0]  dropped_q;
  logic [COUNT_W-1:0] res_total_q;

  logic               out_valid_q;
  logic [COUNT_W-1:0] vote_total_q;
  logic [DROP_W-1:0]  dropped_votes_q;

  logic               rmw_valid_q, rmw_hit_q, rmw_last_q;
  logic [ACC_AW-1:0]  rmw_addr_q;

  logic [COUNT_W-1:0] acc_mem [ACC_DEPTH];
  logic [COUNT_W-1:0] acc_rd_q;

  logic               accept;
  func_e              func;
  logic [ACNT_W-1:0]  n_clip;
  logic               acc_rd_en, acc_we;
  logic [ACC_AW-1:0]  acc_raddr, acc_waddr;
  logic [COUNT_W-1:0] acc_wdata;
  logic [COUNT_W-1:0] acc_inc;
  logic               out_free;

  angle_load_t  load;
  angle_issue_t issue;
  proj_t        proj;

  assign func       = func_e'(func_i);
  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign n_clip     = (angle_count_q > ACNT_W'(ANGLES)) ? ACNT_W'(ANGLES) : angle_count_q;

  // angle table writes go straight through on the accepted beat
  always_comb begin
    load.we     = accept && (func == FUNC_LOAD);
    load.idx    = angle_index_i;
    load.cosine = cosine_value_i;
    load.sine   = sine_value_i;

    issue.valid = (state_q == ST_VOTE);
    issue.last  = (issue_cnt_q == n_q - ACNT_W'(1));
    issue.angle = issue_cnt_q[ANGLE_W-1:0];
  end

  hlv_proj u_proj (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .issue_i      (issue),
    .row_i        (row_q),
    .col_i        (col_q),
    .rho_offset_i (rho_offset_q),
    .proj_o       (proj)
  );

  // accumulator port selection; angles of one vote hit distinct entries,
  // and a vote ends only after its last write, so no forwarding is needed
  always_comb begin
    acc_inc   = (acc_rd_q == '1) ? acc_rd_q : acc_rd_q + COUNT_W'(1);
    acc_rd_en = (accept && (func == FUNC_READ)) || (proj.valid && proj.hit);
    acc_raddr = proj.valid ? proj.addr : {rho_index_i, angle_index_i};
    acc_we    = (state_q == ST_CLEAR) || (rmw_valid_q && rmw_hit_q);
    acc_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : rmw_addr_q;
    acc_wdata = (state_q == ST_CLEAR) ? '0 : acc_inc;
  end

  // accumulator memory
  always_ff @(posedge clk_i) begin
    if (acc_we) begin
      acc_mem[acc_waddr] <= acc_wdata;
    end
    if (acc_rd_en) begin
      acc_rd_q <= acc_mem[acc_raddr];
    end
  end

  // write-back stage sideband
  always_ff @(posedge clk_i) begin
    rmw_hit_q  <= proj.hit;
    rmw_last_q <= proj.last;
    rmw_addr_q <= proj.addr;
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rho_offset_q  <= RHO_OFFSET_RST;
      angle_count_q <= ANGLE_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_RHO_OFFSET:  rho_offset_q  <= cfg_data_i;
        CFG_ANGLE_COUNT: angle_count_q <= cfg_data_i[ACNT_W-1:0];
        default: ;
      endcase
    end
  end

  // item sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_CLEAR;
      clr_cnt_q       <= '0;
      clr_item_q      <= 1'b0;
      issue_cnt_q     <= '0;
      n_q             <= '0;
      row_q           <= '0;
      col_q           <= '0;
      dropped_q       <= '0;
      res_total_q     <= '0;
      rmw_valid_q     <= 1'b0;
      out_valid_q     <= 1'b0;
      vote_total_q    <= '0;
      dropped_votes_q <= '0;
    end else begin
      rmw_valid_q <= proj.valid;

      // the done state loads the next beat itself
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end

      // misses are counted as they leave the projection pipe
      if (proj.valid && !proj.hit && (dropped_q != '1)) begin
        dropped_q <= dropped_q + DROP_W'(1);
      end

      unique case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + ACC_AW'(1);
          if (clr_cnt_q == '1) begin
            state_q <= clr_item_q ? ST_DONE : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            res_total_q <= '0;
            dropped_q   <= '0;
            issue_cnt_q <= '0;
            row_q       <= row_i;
            col_q       <= col_i;
            n_q         <= n_clip;
            unique case (func)
              FUNC_LOAD: state_q <= ST_DONE;
              FUNC_VOTE: begin
                state_q <= ((pixel_value_i != '0) && (n_clip != '0)) ? ST_VOTE : ST_DONE;
              end
              FUNC_READ: state_q <= ST_READ;
              FUNC_CLEAR: begin
                clr_cnt_q  <= '0;
                clr_item_q <= 1'b1;
                state_q    <= ST_CLEAR;
              end
              default: state_q <= ST_DONE;
            endcase
          end
        end
        ST_VOTE: begin
          issue_cnt_q <= issue_cnt_q + ACNT_W'(1);
          if (issue.last) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (rmw_valid_q && rmw_last_q) begin
            state_q <= ST_DONE;
          end
        end
        ST_READ: begin
          res_total_q <= acc_rd_q;
          state_q     <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            out_valid_q     <= 1'b1;
            vote_total_q    <= res_total_q;
            dropped_votes_q <= dropped_q;
            clr_item_q      <= 1'b0;
            state_q         <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign vote_total_o    = vote_total_q;
  assign dropped_votes_o = dropped_votes_q;

  // checks
  `HLV_ASSERT_NEVER(a_rmw_same_entry, acc_we && acc_rd_en && (acc_waddr == acc_raddr),
                    "accumulator read and write hit the same entry")
  `HLV_ASSERT(a_rmw_in_vote, rmw_valid_q |-> (state_q == ST_VOTE || state_q == ST_DRAIN),
              "write-back beat outside a vote")
  `HLV_ASSERT(a_drop_bound, (state_q == ST_DRAIN) |-> (dropped_q <= n_q),
              "more dropped votes than angles")
  `HLV_ASSERT_NEVER(a_clear_no_read, (state_q == ST_CLEAR) && acc_rd_en,
                    "accumulator read during clearing pass")

endmodule

>>> tb/sv/hough_line_vote_unit_test.sv
`timescale 1ns / 1ps

module hough_line_vote_unit_test
  import hlv_pkg::*;
();

  // a clear walks the whole accumulator, so the quiet limit sits well above 2^19
  localparam int unsigned QUIET_LIMIT   = 4 * (1 << 19);
  localparam int unsigned DRAIN_CYCLES  = 300;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS   = 130;
  localparam int unsigned POOL_SIZE     = 6;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned LONG_HOLD_AT  = 200;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam int          NUM_PHASES    = 7;

  typedef struct {
    func_e                    func;
    logic [DIM_W-1:0]         row;
    logic [DIM_W-1:0]         col;
    logic [PIXEL_W-1:0]       pixel;
    logic [ANGLE_W-1:0]       angle;
    logic signed [TRIG_W-1:0] cosv;
    logic signed [TRIG_W-1:0] sinv;
    logic [RHO_W-1:0]         rho_bin;
  } hough_beat_t;

  typedef struct {
    logic [COUNT_W-1:0] total;
    logic [DROP_W-1:0]  dropped;
  } tally_beat_t;

  // register settings per random phase; bit 9 of the count in phase 1 must be ignored
  int phase_offset [NUM_PHASES] = '{1023, 511, 0, 1023, 7, 300, 640};
  int phase_count  [NUM_PHASES] = '{1, 'h210, 0, 511, 8, 24, 12};
  int phase_idle   [NUM_PHASES] = '{20, 0, 35, 10, 25, 15, 0};

  logic                     clk_i           = 1'b0;
  logic                     rst_ni          = 1'b0;
  logic                     cfg_we_i        = 1'b0;
  logic                     cfg_index_i     = CFG_RHO_OFFSET;
  logic [OFFS_W-1:0]        cfg_data_i      = '0;
  logic                     in_valid_i      = 1'b0;
  logic                     in_stall_o;
  logic [1:0]               func_i          = '0;
  logic [DIM_W-1:0]         row_i           = '0;
  logic [DIM_W-1:0]         col_i           = '0;
  logic [PIXEL_W-1:0]       pixel_value_i   = '0;
  logic [ANGLE_W-1:0]       angle_index_i   = '0;
  logic signed [TRIG_W-1:0] cosine_value_i  = '0;
  logic signed [TRIG_W-1:0] sine_value_i    = '0;
  logic [RHO_W-1:0]         rho_index_i     = '0;
  logic                     out_valid_o;
  logic                     out_stall_i     = 1'b0;
  logic [COUNT_W-1:0]       vote_total_o;
  logic [DROP_W-1:0]        dropped_votes_o;

  // predictor state
  logic signed [TRIG_W-1:0] model_cos [ANGLES];
  logic signed [TRIG_W-1:0] model_sin [ANGLES];
  logic [COUNT_W-1:0]       vote_bins [int];
  logic [OFFS_W-1:0]        rho_offset_q  = RHO_OFFSET_RST;
  logic [ACNT_W-1:0]        angle_count_q = ANGLE_COUNT_RST;
  tally_beat_t              expected_results [$];

  // stimulus side view of the angle table, used to aim reads at live bins
  logic signed [TRIG_W-1:0] gen_cos [ANGLES];
  logic signed [TRIG_W-1:0] gen_sin [ANGLES];
  bit                       gen_loaded [ANGLES];
  logic [DIM_W-1:0]         pool_row [POOL_SIZE];
  logic [DIM_W-1:0]         pool_col [POOL_SIZE];
  hough_beat_t              pending_items [$];

  hough_beat_t cur_beat;
  tally_beat_t want;
  int          idle_pct = 20;
  int unsigned gap_left, stall_left, quiet_cycles;
  bit          long_hold_done;
  int unsigned queued_items, accepted_items, results_seen, fail_count, reg_writes;
  int unsigned load_beats, vote_beats, read_beats, clear_beats, dropped_angles, nonzero_reads;

  hough_line_vote_unit u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .row_i          (row_i),
    .col_i          (col_i),
    .pixel_value_i  (pixel_value_i),
    .angle_index_i  (angle_index_i),
    .cosine_value_i (cosine_value_i),
    .sine_value_i   (sine_value_i),
    .rho_index_i    (rho_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .vote_total_o   (vote_total_o),
    .dropped_votes_o(dropped_votes_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // angles walked per vote, counts above the table size clip to it
  function automatic int angles_in_use();
    return (angle_count_q > ANGLES) ? int'(ANGLES) : int'(angle_count_q);
  endfunction

  // round half up of the q1.14 projection, before the offset
  function automatic longint project_rho(input logic signed [TRIG_W-1:0] c,
                                         input logic signed [TRIG_W-1:0] s,
                                         input logic [DIM_W-1:0] r,
                                         input logic [DIM_W-1:0] x);
    longint sum;
    sum = longint'(c) * longint'(x) + longint'(s) * longint'(r);
    return (sum + longint'(1 << (FRAC_W - 1))) >>> FRAC_W;
  endfunction

  task automatic predict_beat(input hough_beat_t b);
    tally_beat_t        res;
    longint             rho, top;
    int                 key, n, j;
    logic [COUNT_W-1:0] cnt;
    res.total   = '0;
    res.dropped = '0;
    case (b.func)
      FUNC_LOAD: begin
        model_cos[b.angle] = b.cosv;
        model_sin[b.angle] = b.sinv;
        load_beats++;
      end
      FUNC_VOTE: begin
        vote_beats++;
        n   = angles_in_use();
        top = 2 * longint'(rho_offset_q);
        if (b.pixel != '0) begin
          for (j = 0; j < n; j++) begin
            rho = project_rho(model_cos[j], model_sin[j], b.row, b.col)
                  + longint'(rho_offset_q);
            if (rho < 0 || rho > top || rho >= longint'(RHO_BINS)) begin
              if (res.dropped != '1) res.dropped = res.dropped + 1'b1;
            end else begin
              key = int'(rho) * int'(ANGLES) + j;
              cnt = vote_bins.exists(key) ? vote_bins[key] : '0;
              // counters stick at their maximum
              if (cnt != '1) vote_bins[key] = cnt + 1'b1;
            end
          end
          dropped_angles += res.dropped;
        end
      end
      FUNC_READ: begin
        read_beats++;
        key = int'(b.rho_bin) * int'(ANGLES) + int'(b.angle);
        if (vote_bins.exists(key)) res.total = vote_bins[key];
        if (res.total != '0) nonzero_reads++;
      end
      FUNC_CLEAR: begin
        vote_bins.delete();
        clear_beats++;
      end
    endcase
    expected_results.push_back(res);
  endtask

  // unused fields carry random bits on every beat
  function automatic hough_beat_t noise_beat(input func_e f);
    hough_beat_t b;
    b.func    = f;
    b.row     = DIM_W'($urandom);
    b.col     = DIM_W'($urandom);
    b.pixel   = PIXEL_W'($urandom);
    b.angle   = ANGLE_W'($urandom);
    b.cosv    = TRIG_W'($urandom);
    b.sinv    = TRIG_W'($urandom);
    b.rho_bin = RHO_W'($urandom);
    return b;
  endfunction

  function automatic int trig_sample();
    return int'($urandom_range(0, 32768)) - 16384;
  endfunction

  task automatic add_beat(input hough_beat_t b);
    if (b.func == FUNC_LOAD) begin
      gen_cos[b.angle]    = b.cosv;
      gen_sin[b.angle]    = b.sinv;
      gen_loaded[b.angle] = 1'b1;
    end
    pending_items.push_back(b);
    queued_items++;
  endtask

  task automatic add_load(input int a, input int c, input int s);
    hough_beat_t b;
    b       = noise_beat(FUNC_LOAD);
    b.angle = ANGLE_W'(a);
    b.cosv  = TRIG_W'(c);
    b.sinv  = TRIG_W'(s);
    add_beat(b);
  endtask

  task automatic add_vote(input logic [DIM_W-1:0] r, input logic [DIM_W-1:0] x,
                          input logic [PIXEL_W-1:0] p);
    hough_beat_t b;
    b       = noise_beat(FUNC_VOTE);
    b.row   = r;
    b.col   = x;
    b.pixel = p;
    add_beat(b);
  endtask

  task automatic add_read(input logic [RHO_W-1:0] rb, input logic [ANGLE_W-1:0] a);
    hough_beat_t b;
    b         = noise_beat(FUNC_READ);
    b.rho_bin = rb;
    b.angle   = a;
    add_beat(b);
  endtask

  // mostly votes on a few repeated points, with reads aimed at the bins they hit
  task automatic add_random_beat();
    int          pick, p, j, n;
    longint      rho;
    logic [15:0] pix;
    pick = $urandom_range(0, 99);
    n    = angles_in_use();
    p    = $urandom_range(0, POOL_SIZE - 1);
    if (pick < 15) begin
      j = ($urandom_range(0, 1) && n != 0) ? $urandom_range(0, n - 1)
                                            : $urandom_range(0, ANGLES - 1);
      if ($urandom_range(0, 4) == 0) add_load(j, $urandom, $urandom);
      else add_load(j, trig_sample(), trig_sample());
    end else if (pick < 65) begin
      pix = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
      if ($urandom_range(0, 9) < 7) add_vote(pool_row[p], pool_col[p], pix);
      else add_vote(DIM_W'($urandom), DIM_W'($urandom), pix);
    end else begin
      j   = (n != 0) ? $urandom_range(0, n - 1) : 0;
      rho = project_rho(gen_cos[j], gen_sin[j], pool_row[p], pool_col[p])
            + longint'(rho_offset_q);
      if (n != 0 && $urandom_range(0, 3) != 0 && rho >= 0 && rho < longint'(RHO_BINS))
        add_read(RHO_W'(rho), ANGLE_W'(j));
      else add_read(RHO_W'($urandom), ANGLE_W'($urandom));
    end
  endtask

  task automatic write_reg(input logic idx, input int data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= OFFS_W'(data);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_RHO_OFFSET) rho_offset_q = OFFS_W'(data);
    else angle_count_q = ACNT_W'(data);
    reg_writes++;
  endtask

  // wait until every queued beat went in and its result came back
  task automatic settle();
    while (accepted_items != queued_items || expected_results.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // input driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        predict_beat(cur_beat);
        accepted_items++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
          gap_left = $urandom_range(1, 6) - 1;
          in_valid_i <= 1'b0;
        end else if (pending_items.size() != 0) begin
          cur_beat = pending_items.pop_front();
          in_valid_i     <= 1'b1;
          func_i         <= cur_beat.func;
          row_i          <= cur_beat.row;
          col_i          <= cur_beat.col;
          pixel_value_i  <= cur_beat.pixel;
          angle_index_i  <= cur_beat.angle;
          cosine_value_i <= cur_beat.cosv;
          sine_value_i   <= cur_beat.sinv;
          rho_index_i    <= cur_beat.rho_bin;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor and output stall pattern
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result beat: total %0d dropped %0d",
                     vote_total_o, dropped_votes_o);
        end else begin
          want = expected_results.pop_front();
          if (want.total !== vote_total_o || want.dropped !== dropped_votes_o) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display({"result %0d mismatch: expected total %0d dropped %0d, ",
                        "got total %0d dropped %0d"},
                       results_seen, want.total, want.dropped, vote_total_o,
                       dropped_votes_o);
          end
        end
      end
      // one long hold-off so the block backs up into its input
      if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
        long_hold_done = 1'b1;
        stall_left     = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(1, 6) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
      $display("[hough_line_vote_unit] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int p, a, k, n;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: four known angles plus the widest values on the top entry
    write_reg(CFG_RHO_OFFSET, 1023);
    write_reg(CFG_ANGLE_COUNT, 4);
    @(negedge clk_i);
    add_load(0, 16384, 0);
    add_load(1, 0, 16384);
    add_load(2, -16384, -16384);
    add_load(3, 8192, -8192);
    add_load(ANGLES - 1, -32768, 32767);
    add_vote(0, 0, 1);
    add_vote(1023, 1023, 16'hFFFF);
    add_vote(1, 1, 16'h8000);
    // exact halves on both signs round up
    add_vote(0, 1, 1);
    add_vote(1, 0, 1);
    // zero pixel casts nothing
    add_vote(5, 5, 0);
    add_read(1023, 0);
    add_read(2046, 0);
    add_read(2047, ANGLES - 1);
    add_read(1024, 3);
    add_beat(noise_beat(FUNC_CLEAR));
    add_read(1023, 0);
    settle();

    // zero offset: anything off bin zero falls out of range
    write_reg(CFG_RHO_OFFSET, 0);
    @(negedge clk_i);
    add_vote(3, 2, 7);
    add_vote(0, 0, 1);
    add_read(0, 3);
    add_read(0, 0);

    for (p = 0; p < NUM_PHASES; p++) begin
      settle();
      idle_pct = phase_idle[p];
      write_reg(CFG_RHO_OFFSET, phase_offset[p]);
      write_reg(CFG_ANGLE_COUNT, phase_count[p]);
      @(negedge clk_i);
      n = angles_in_use();
      // every angle in use gets a table entry before it votes
      for (a = 0; a < n; a++)
        if (!gen_loaded[a]) add_load(a, trig_sample(), trig_sample());
      for (k = 0; k < POOL_SIZE; k++) begin
        pool_row[k] = DIM_W'($urandom);
        pool_col[k] = DIM_W'($urandom);
      end
      for (k = 0; k < PHASE_ITEMS; k++) add_random_beat();
    end
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (expected_results.size() != 0) fail_count++;
    $display("ran %0d loads, %0d votes (%0d angle votes out of range),",
             load_beats, vote_beats, dropped_angles);
    $display("%0d reads (%0d nonzero), %0d clears, %0d register writes",
             read_beats, nonzero_reads, clear_beats, reg_writes);
    $display("%0d result beats checked, %0d failures", results_seen, fail_count);
    if (fail_count == 0) $display("[hough_line_vote_unit] OK");
    else $display("[hough_line_vote_unit] ERROR");
    $finish;
  end

endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/hlv_pkg.sv
hw/rtl/hlv_proj.sv
hw/rtl/hough_line_vote_unit.sv
tb/sv/hough_line_vote_unit_test.sv
